>>> rtl/rpn_doc_set_query_stack_macros.svh
// Assertion macros shared by the query stack RTL.
// Needs nothing else; include by bare file name.
`ifndef RPN_DOC_SET_QUERY_STACK_MACROS_SVH
`define RPN_DOC_SET_QUERY_STACK_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define RDSQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdsq assertion failed");

// next-cycle implication under synchronous active-low reset
`define RDSQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdsq assertion failed");

`endif

>>> rtl/rdsq_pkg.sv
`timescale 1ns / 1ps
// Package for the RPN document set query stack: sizes, codes, word types
// and the document mask function. Depends on nothing.
package rdsq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MAX_DOCS    = 64;

    localparam int DOCS_W      = 64;
    localparam int ACTION_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int DEPTH_OUT_W = 5;
    localparam int STATUS_W    = 2;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_LEAF   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_AND    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_OR     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NOT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT = 2'd3;

    localparam logic [COUNT_W-1:0] DOC_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DOCS_W-1:0]   leaf_docs;
    } in_word_t;

    typedef struct packed {
        logic [DOCS_W-1:0]      top_docs;
        logic [DEPTH_OUT_W-1:0] stack_depth;
        logic [STATUS_W-1:0]    status;
        logic                   query_done;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic from_upper;
    } cell_ctl_t;

    function automatic logic [DOCS_W-1:0] docs_mask(input logic [COUNT_W-1:0] count);
        logic [DOCS_W-1:0] m;
        m = '0;
        for (int i = 0; i < DOCS_W; i++) begin
            m[i] = (i < MAX_DOCS) && (int'(count) > i);
        end
        return m;
    endfunction

endpackage

>>> rtl/rdsq_cell.sv
`timescale 1ns / 1ps
// One stack cell: holds a single document set and takes its neighbour's.
// Depends on rdsq_pkg.
module rdsq_cell (
    input  logic                        aclk,
    input  rdsq_pkg::cell_ctl_t         ctl,
    input  logic [rdsq_pkg::DOCS_W-1:0] upper_docs,
    input  logic [rdsq_pkg::DOCS_W-1:0] lower_docs,
    output logic [rdsq_pkg::DOCS_W-1:0] docs
);

    logic [rdsq_pkg::DOCS_W-1:0] docs_reg;
    logic [rdsq_pkg::DOCS_W-1:0] docs_next;

    always_comb begin
        docs_next = docs_reg;
        if (ctl.load) begin
            docs_next = ctl.from_upper ? upper_docs : lower_docs;
        end
    end

    always_ff @(posedge aclk) begin
        docs_reg <= docs_next;
    end

    assign docs = docs_reg;

endmodule

>>> rtl/rdsq_obuf.sv
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
// Depends on rdsq_pkg.
module rdsq_obuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rdsq_pkg::out_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output rdsq_pkg::out_word_t out_word
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    rdsq_pkg::out_word_t out_word_reg, out_word_next;
    rdsq_pkg::out_word_t skid_word_reg, skid_word_next;
    logic                in_fire;
    logic                out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_word_next  = in_word;
                out_valid_next = in_fire;
            end
        end else if (in_fire) begin
            skid_word_next  = in_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> rtl/rpn_doc_set_query_stack.sv
`timescale 1ns / 1ps
// Top level of the RPN document set query stack: depth counter, top-of-stack
// logic, a chain of rdsq_cell and the rdsq_obuf result buffer. Uses rdsq_pkg.
//
//  channel   ports                              direction  word
//  input     s_valid  s_ready  s_word           in         in_word_t
//  result    m_valid  m_ready  m_word           out        out_word_t
//  config    cfg_wr_en  cfg_wr_data             in         doc_count
//
// One word a cycle while s_ready is high: each word is decoded and applied to the cell
// chain in the cycle it is taken; its result is registered in the output or skid register.
// The cell chain shifts by one place per word, which sets the single-cycle rate.
// Reset empties the stack and sets doc_count to 64; there is no clearing pass.
// With m_ready low, one further word is taken into the skid register, then
// s_ready drops until the output register drains.
`include "rpn_doc_set_query_stack_macros.svh"

module rpn_doc_set_query_stack (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rdsq_pkg::in_word_t                 s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rdsq_pkg::out_word_t                m_word,
    input  logic                               cfg_wr_en,
    input  logic [rdsq_pkg::COUNT_W-1:0]       cfg_wr_data
);

    localparam int N = rdsq_pkg::STACK_DEPTH;

    logic [rdsq_pkg::DOCS_W-1:0] mask_reg;
    logic [rdsq_pkg::PTR_W-1:0]  depth_reg, depth_next;
    logic [rdsq_pkg::DOCS_W-1:0] cell_docs [N];
    logic [rdsq_pkg::DOCS_W-1:0] upper_docs [N];
    logic [rdsq_pkg::DOCS_W-1:0] lower_docs [N];
    rdsq_pkg::cell_ctl_t         cell_ctl [N];

    logic [rdsq_pkg::DOCS_W-1:0] top_cur;
    logic [rdsq_pkg::DOCS_W-1:0] new_top;
    logic [rdsq_pkg::DOCS_W-1:0] res_top;
    logic [rdsq_pkg::STATUS_W-1:0] res_status;
    logic                        res_done;
    logic                        do_push, do_pop, do_top;
    logic                        s_fire;
    rdsq_pkg::out_word_t         res_word;
    logic                        over_fire;
    logic                        under_fire;
    logic                        leaf_on_full;

    assign s_fire  = s_valid && s_ready;
    assign top_cur = (depth_reg != '0) ? cell_docs[0] : '0;

    always_comb begin
        new_top    = '0;
        res_top    = top_cur;
        res_status = rdsq_pkg::ST_OK;
        res_done   = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_top     = 1'b0;
        depth_next = depth_reg;
        unique case (s_word.action)
            rdsq_pkg::ACT_LEAF: begin
                if (depth_reg >= rdsq_pkg::PTR_W'(N)) begin
                    res_status = rdsq_pkg::ST_OVER;
                end else begin
                    new_top    = s_word.leaf_docs & mask_reg;
                    res_top    = new_top;
                    do_push    = 1'b1;
                    do_top     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            rdsq_pkg::ACT_AND, rdsq_pkg::ACT_OR: begin
                if (depth_reg < rdsq_pkg::PTR_W'(2)) begin
                    res_status = rdsq_pkg::ST_UNDER;
                end else begin
                    new_top    = ((s_word.action == rdsq_pkg::ACT_AND)
                                  ? (cell_docs[0] & cell_docs[1])
                                  : (cell_docs[0] | cell_docs[1])) & mask_reg;
                    res_top    = new_top;
                    do_pop     = 1'b1;
                    do_top     = 1'b1;
                    depth_next = depth_reg - 1'b1;
                end
            end
            rdsq_pkg::ACT_NOT: begin
                if (depth_reg == '0) begin
                    res_status = rdsq_pkg::ST_UNDER;
                end else begin
                    new_top = ~cell_docs[0] & mask_reg;
                    res_top = new_top;
                    do_top  = 1'b1;
                end
            end
            rdsq_pkg::ACT_FINISH: begin
                if (depth_reg != rdsq_pkg::PTR_W'(1)) begin
                    res_status = rdsq_pkg::ST_COUNT;
                end
                res_done   = 1'b1;
                depth_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            cell_ctl[i].from_upper = (i == 0) || do_push;
            cell_ctl[i].load       = s_fire && ((i == 0) ? do_top : (do_push || do_pop));
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign upper_docs[g] = new_top;
            end else begin : g_body
                assign upper_docs[g] = cell_docs[g-1];
            end
            if (g == N - 1) begin : g_tail
                assign lower_docs[g] = '0;
            end else begin : g_link
                assign lower_docs[g] = cell_docs[g+1];
            end
            rdsq_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl[g]),
                .upper_docs (upper_docs[g]),
                .lower_docs (lower_docs[g]),
                .docs       (cell_docs[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            mask_reg  <= rdsq_pkg::docs_mask(rdsq_pkg::DOC_COUNT_RESET);
        end else begin
            if (s_fire) begin
                depth_reg <= depth_next;
            end
            if (cfg_wr_en) begin
                mask_reg <= rdsq_pkg::docs_mask(cfg_wr_data);
            end
        end
    end

    assign res_word.top_docs    = res_top;
    assign res_word.stack_depth = rdsq_pkg::DEPTH_OUT_W'(depth_next);
    assign res_word.status      = res_status;
    assign res_word.query_done  = res_done;

    rdsq_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (res_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

    assign over_fire    = s_fire && (res_status == rdsq_pkg::ST_OVER);
    assign under_fire   = s_fire && (res_status == rdsq_pkg::ST_UNDER);
    assign leaf_on_full = (s_word.action == rdsq_pkg::ACT_LEAF)
                          && (depth_reg == rdsq_pkg::PTR_W'(N));

    `RDSQ_ASSERT_NOW(a_depth_bound, aclk, aresetn, 1'b1, depth_reg <= rdsq_pkg::PTR_W'(N))
    `RDSQ_ASSERT_NEXT(a_finish_empties, aclk, aresetn, s_fire && res_done, depth_reg == '0)
    `RDSQ_ASSERT_NOW(a_over_when_full, aclk, aresetn, over_fire, leaf_on_full)
    `RDSQ_ASSERT_NEXT(a_under_holds, aclk, aresetn, under_fire, depth_reg == $past(depth_reg))

endmodule

>>> dv/rpn_doc_set_query_stack_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rpn_doc_set_query_stack: directed and random RPN queries
// over document bitmaps, a stack predictor and an in-order result scoreboard.
// Depends on rdsq_pkg and the block's RTL.
module rpn_doc_set_query_stack_tb;
    import rdsq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 42;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_word_t             s_word      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_word_t            m_word;
    logic                 cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data = '0;

    in_word_t             query_words[$];
    out_word_t            due_results[$];
    logic [DOCS_W-1:0]    doc_stack[STACK_DEPTH];
    int                   depth       = 0;
    logic [COUNT_W-1:0]   doc_count_q = DOC_COUNT_RESET;

    int   words_queued   = 0;
    int   words_accepted = 0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    int   hold_trigger   = 0;
    int   hold_ack       = 0;
    int   hold_left      = 0;
    logic word_taken     = 1'b0;

    rpn_doc_set_query_stack dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic out_word_t apply_query_word(input in_word_t w);
        logic [DOCS_W-1:0] mask;
        logic [DOCS_W-1:0] a;
        logic [DOCS_W-1:0] b;
        int                n;
        out_word_t         r;
        n    = (int'(doc_count_q) > MAX_DOCS) ? MAX_DOCS : int'(doc_count_q);
        mask = (n >= DOCS_W) ? '1 : ((64'd1 << n) - 64'd1);
        r    = '0;
        r.status = ST_OK;
        case (w.action)
            ACT_LEAF: begin
                if (depth >= STACK_DEPTH) begin
                    r.status = ST_OVER;
                end else begin
                    doc_stack[depth] = w.leaf_docs & mask;
                    depth++;
                end
            end
            ACT_AND, ACT_OR: begin
                if (depth < 2) begin
                    r.status = ST_UNDER;
                end else begin
                    a = doc_stack[depth-1];
                    b = doc_stack[depth-2];
                    depth--;
                    doc_stack[depth-1] = ((w.action == ACT_AND) ? (a & b) : (a | b)) & mask;
                end
            end
            ACT_NOT: begin
                if (depth < 1) begin
                    r.status = ST_UNDER;
                end else begin
                    doc_stack[depth-1] = ~doc_stack[depth-1] & mask;
                end
            end
            ACT_FINISH: begin
                r.top_docs   = (depth == 0) ? '0 : doc_stack[depth-1];
                r.query_done = 1'b1;
                if (depth != 1) begin
                    r.status = ST_COUNT;
                end
                depth = 0;
            end
            default: begin
            end
        endcase
        if (w.action != ACT_FINISH) begin
            r.top_docs = (depth == 0) ? '0 : doc_stack[depth-1];
        end
        r.stack_depth = DEPTH_OUT_W'(depth);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input out_word_t want, input out_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s) at %0t: expected top=%h depth=%0d status=%0d done=%0d",
                     what, $realtime, want.top_docs, want.stack_depth, want.status,
                     want.query_done);
            $display("    got top=%h depth=%0d status=%0d done=%0d",
                     got.top_docs, got.stack_depth, got.status, got.query_done);
        end
    endtask

    // predict on every accepted word, check every accepted result
    always @(posedge aclk) begin : result_monitor
        out_word_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_valid && s_ready;
            if (cfg_wr_en) begin
                doc_count_q = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                due_results.insert(due_results.size(), apply_query_word(s_word));
                words_accepted++;
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected word", '0, m_word);
                end else begin
                    want = due_results.pop_front();
                    if (m_word.top_docs !== want.top_docs
                            || m_word.stack_depth !== want.stack_depth
                            || m_word.status !== want.status
                            || m_word.query_done !== want.query_done) begin
                        flag_mismatch("field", want, m_word);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (query_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_word  <= query_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_trigger != hold_ack) begin
            hold_ack  = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [DOCS_W-1:0] rand_docs();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, DOCS_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [DOCS_W-1:0] docs);
        in_word_t w;
        w.action    = act;
        w.leaf_docs = docs;
        query_words.insert(query_words.size(), w);
        words_queued++;
    endtask

    task automatic queue_query();
        int kind;
        int d;
        int leaves_left;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise: any action, then close
            repeat ($urandom_range(1, 8)) begin
                queue_word(ACTION_W'($urandom_range(0, 7)), rand_docs());
            end
            queue_word(ACT_FINISH, rand_docs());
        end else if (kind == 1) begin
            // fill to around capacity, sometimes past it
            repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2)) begin
                queue_word(ACT_LEAF, rand_docs());
            end
            repeat ($urandom_range(0, 4)) begin
                queue_word(ACTION_W'($urandom_range(1, 3)), rand_docs());
            end
            queue_word(ACT_FINISH, rand_docs());
        end else begin
            d           = 0;
            leaves_left = $urandom_range(1, 7);
            while (leaves_left > 0 || d > 1) begin
                if (d >= 2 && (leaves_left == 0 || $urandom_range(0, 2) == 0)) begin
                    queue_word($urandom_range(0, 1) ? ACT_AND : ACT_OR, rand_docs());
                    d--;
                end else if (d >= 1 && $urandom_range(0, 4) == 0) begin
                    queue_word(ACT_NOT, rand_docs());
                end else begin
                    queue_word(ACT_LEAF, rand_docs());
                    d++;
                    leaves_left--;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                queue_word(ACT_NOT, rand_docs());
            end
            queue_word(ACT_FINISH, rand_docs());
        end
    endtask

    task automatic drain();
        while (words_accepted != words_queued || due_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_doc_count(input logic [COUNT_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int                 phase_start;
        logic [COUNT_W-1:0] count;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_word(ACT_FINISH, '1);
        queue_word(ACT_AND, '1);
        queue_word(ACT_NOT, '0);
        queue_word(ACT_UNUSED, '1);
        for (int i = 0; i <= STACK_DEPTH; i++) begin
            if (i == 0) begin
                queue_word(ACT_LEAF, '1);
            end else if (i == 1) begin
                queue_word(ACT_LEAF, '0);
            end else if (i == 2) begin
                queue_word(ACT_LEAF, 64'hAAAA_AAAA_AAAA_AAAA);
            end else begin
                queue_word(ACT_LEAF, {$urandom, $urandom});
            end
        end
        queue_word(ACT_AND, '0);
        queue_word(ACT_OR, '1);
        queue_word(ACT_NOT, '0);
        queue_word(ACT_FINISH, '0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       count = DOC_COUNT_RESET;
                1:       count = 7'd0;
                2:       count = 7'd1;
                3:       count = 7'd127;
                4:       count = 7'd64;
                5:       count = COUNT_W'($urandom_range(2, 63));
                6:       count = COUNT_W'($urandom_range(65, 126));
                default: count = COUNT_W'($urandom_range(0, 127));
            endcase
            write_doc_count(count);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS) begin
                queue_query();
            end
            // stall the result side long enough to back up the input
            if (p == 4) begin
                hold_trigger++;
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        mismatch_count += due_results.size();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
